>>> rtl/core/skvt_pkg.sv
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types and codes of the sorted key/value table.
// ----------------------------------------------------------------------------
`default_nettype none

package skvt_pkg;

	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_LOOKUP = 2'd1,
		FN_CLEAR  = 2'd2,
		FN_NOP    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_ORDER     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

endpackage

`default_nettype wire

>>> rtl/core/skvt_req_if.sv
// ----------------------------------------------------------------------------
// skvt_req_if
// Request channel: operation, key and value with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface skvt_req_if;
	logic                        valid;
	logic                        ready;
	skvt_pkg::func_t             func;
	logic [skvt_pkg::KEY_W-1:0]  key;
	logic [skvt_pkg::VAL_W-1:0]  value;

	modport source (output valid, func, key, value, input ready);
	modport sink   (input valid, func, key, value, output ready);
endinterface

`default_nettype wire

>>> rtl/core/skvt_rsp_if.sv
// ----------------------------------------------------------------------------
// skvt_rsp_if
// Response channel: found flag, value and status with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface skvt_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        found;
	logic [skvt_pkg::VAL_W-1:0]  value_out;
	skvt_pkg::status_t           status;

	modport source (output valid, found, value_out, status, input ready);
	modport sink   (input valid, found, value_out, status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/skvt_ram.sv
// ----------------------------------------------------------------------------
// skvt_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module skvt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/sorted_key_value_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table_unit
// Append-only key/value map kept in ascending key order, binary-search lookup.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one transaction per operation: insert (key must exceed the
//   last key stored), lookup, or clear. rsp returns exactly one transaction
//   per request: found flag, value and status.
//   Insert, clear and the unused code answer in the cycle after acceptance;
//   the next request can be taken in the following cycle if rsp.ready is set.
//   A lookup over n stored entries probes the key RAM once per cycle, each
//   probe address taken from the key read back by the previous probe
//   from the registered RAM output. An empty table answers like an insert.
//   Reset clears the entry count, last key and the response valid flag; the
//   RAM contents are not cleared and need no clearing pass.
//   A stalled rsp keeps its result; a new request is taken only once the
//   response register is free or being drained in the same cycle, and a
//   finished lookup waits in a hold state until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_value_table_unit #(
	parameter int DEPTH       = 1024,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	skvt_req_if.sink    req,
	skvt_rsp_if.source  rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int VW = skvt_pkg::VAL_W;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SEARCH = 3'b010,
		S_DONE   = 3'b100
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          count_q;
	logic [KEY_WIDTH-1:0]   last_key_q;
	logic                   rsp_valid_q;
	logic                   rsp_found_q;
	logic [VW-1:0]          rsp_value_q;
	skvt_pkg::status_t      rsp_status_q;

	logic [CW-1:0]          lo_q, hi_q, mid_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic                   found_q;
	logic [VALUE_WIDTH-1:0] val_q;

	logic                   slot_free, req_fire, is_lookup, start_search;
	logic [KEY_WIDTH-1:0]   k_in;
	logic [VALUE_WIDTH-1:0] v_in;
	logic                   ins_order, ins_full, ins_ok;
	logic [CW-1:0]          half_cnt;

	logic [KEY_WIDTH-1:0]   key_rd;
	logic [VALUE_WIDTH-1:0] val_rd;
	logic                   key_lt, key_eq, more, hit;
	logic [CW-1:0]          lo_n, hi_n, mid_n;
	logic [VALUE_WIDTH-1:0] hit_val;

	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic                   load_rsp;
	logic                   rsp_found_d;
	logic [VW-1:0]          rsp_value_d;
	skvt_pkg::status_t      rsp_status_d;

	assign slot_free    = !rsp_valid_q || rsp.ready;
	assign req.ready    = (state_q == S_IDLE) && slot_free;
	assign req_fire     = req.valid && req.ready;
	assign k_in         = KEY_WIDTH'(req.key);
	assign v_in         = VALUE_WIDTH'(req.value);
	assign is_lookup    = (req.func == skvt_pkg::FN_LOOKUP);
	assign start_search = req_fire && is_lookup && (count_q != '0);
	assign half_cnt     = count_q >> 1;

	assign ins_order = (count_q != '0) && (k_in <= last_key_q);
	assign ins_full  = (count_q == CW'(DEPTH));
	assign ins_ok    = req_fire && (req.func == skvt_pkg::FN_INSERT) && !ins_order && !ins_full;

	// one lower-bound step per cycle on the key read back for mid_q
	assign key_lt  = key_rd < key_q;
	assign key_eq  = key_rd == key_q;
	assign lo_n    = key_lt ? mid_q + CW'(1) : lo_q;
	assign hi_n    = key_lt ? hi_q : mid_q;
	assign mid_n   = lo_n + ((hi_n - lo_n) >> 1);
	assign more    = lo_n < hi_n;
	// keys are unique, so a probe that matches is the final position
	assign hit     = found_q || key_eq;
	assign hit_val = key_eq ? val_rd : val_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = mid_n[AW-1:0];
		if (start_search) begin
			rd_en   = 1'b1;
			rd_addr = half_cnt[AW-1:0];
		end else if (state_q == S_SEARCH && more) begin
			rd_en = 1'b1;
		end
	end

	skvt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_key_ram (
		.clk   (clk),
		.we    (ins_ok),
		.waddr (count_q[AW-1:0]),
		.wdata (k_in),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (key_rd)
	);

	skvt_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_val_ram (
		.clk   (clk),
		.we    (ins_ok),
		.waddr (count_q[AW-1:0]),
		.wdata (v_in),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (val_rd)
	);

	always_comb begin
		load_rsp     = 1'b0;
		rsp_found_d  = 1'b0;
		rsp_value_d  = '0;
		rsp_status_d = skvt_pkg::ST_OK;
		case (state_q)
			S_IDLE: begin
				load_rsp = req_fire && !start_search;
				case (req.func)
					skvt_pkg::FN_INSERT: begin
						if (ins_order) begin
							rsp_status_d = skvt_pkg::ST_ORDER;
						end else if (ins_full) begin
							rsp_status_d = skvt_pkg::ST_FULL;
						end
					end
					skvt_pkg::FN_LOOKUP: rsp_status_d = skvt_pkg::ST_NOT_FOUND;
					default:             rsp_status_d = skvt_pkg::ST_OK;
				endcase
			end
			S_SEARCH: begin
				load_rsp     = !more && slot_free;
				rsp_found_d  = hit;
				rsp_value_d  = hit ? VW'(hit_val) : '0;
				rsp_status_d = hit ? skvt_pkg::ST_OK : skvt_pkg::ST_NOT_FOUND;
			end
			S_DONE: begin
				load_rsp     = slot_free;
				rsp_found_d  = found_q;
				rsp_value_d  = found_q ? VW'(val_q) : '0;
				rsp_status_d = found_q ? skvt_pkg::ST_OK : skvt_pkg::ST_NOT_FOUND;
			end
			default: begin
				load_rsp = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			last_key_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start_search) begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (!more) begin
						state_q <= slot_free ? S_IDLE : S_DONE;
					end
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (ins_ok) begin
				count_q    <= count_q + CW'(1);
				last_key_q <= k_in;
			end else if (req_fire && req.func == skvt_pkg::FN_CLEAR) begin
				count_q    <= '0;
				last_key_q <= '0;
			end

			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_search) begin
			lo_q    <= '0;
			hi_q    <= count_q;
			mid_q   <= half_cnt;
			key_q   <= k_in;
			found_q <= 1'b0;
		end else if (state_q == S_SEARCH) begin
			lo_q    <= lo_n;
			hi_q    <= hi_n;
			mid_q   <= mid_n;
			found_q <= hit;
			val_q   <= hit_val;
		end
		if (load_rsp) begin
			rsp_found_q  <= rsp_found_d;
			rsp_value_q  <= rsp_value_d;
			rsp_status_q <= rsp_status_d;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.found     = rsp_found_q;
	assign rsp.value_out = rsp_value_q;
	assign rsp.status    = rsp_status_q;

endmodule

`default_nettype wire

>>> rtl/core/skvt_checker.sv
// ----------------------------------------------------------------------------
// skvt_checker
// Port-level checks of the sorted key/value table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module skvt_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        req_valid,
	input wire logic                        req_ready,
	input wire logic [1:0]                  req_func,
	input wire logic                        rsp_valid,
	input wire logic                        rsp_ready,
	input wire logic                        rsp_found,
	input wire logic [skvt_pkg::VAL_W-1:0]  rsp_value_out,
	input wire logic [1:0]                  rsp_status
);

	// a stalled response stays up
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_found |-> rsp_status == skvt_pkg::ST_OK)
		else $error("found response without ok status");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_value_out == '0)
		else $error("nonzero value on a miss");

	// non-lookup transactions answer in the next cycle
	a_fast_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_func != skvt_pkg::FN_LOOKUP |=> rsp_valid)
		else $error("missing response after insert or clear");

	a_no_take_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !(req_valid && req_ready))
		else $error("request taken while response is stalled");

endmodule

bind sorted_key_value_table_unit skvt_checker u_skvt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_func      (req.func),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_found     (rsp.found),
	.rsp_value_out (rsp.value_out),
	.rsp_status    (rsp.status)
);

`default_nettype wire
